// ===== hw/rtl/crt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the two-moduli CRT solver.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int DefWidth = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_INIT,
    ST_DIV,
    ST_UPDATE,
    ST_MUL_A0,
    ST_MUL_A1,
    ST_MUL_B0,
    ST_MUL_B1,
    ST_RED_INIT,
    ST_RED,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/crt_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_divider
// Restoring divider, one quotient bit per cycle, unsigned N-bit operands.
// ----------------------------------------------------------------------------
module crt_divider #(
  parameter int N = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic [N-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quo;
  logic [N:0]    rem;
  logic [N-1:0]  dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [N:0]    trial;
  logic [N:0]    diff;

  assign trial = {rem[N-1:0], quo[N-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(N);
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        if (diff[N]) begin
          rem <= trial;
          quo <= {quo[N-2:0], 1'b0};
        end else begin
          rem <= diff;
          quo <= {quo[N-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[N-1:0];

endmodule

// ===== hw/rtl/crt_two_moduli_solver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_two_moduli_solver_unit
// Sequence: Euclid steps in the one serial divider, up to about 1.5*WIDTH
// steps, then four multiply states, a bit-serial reduction modulo the product
// and a sign fix.
// One word at a time; not ready until the result is taken.
// Synchronous reset returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
module crt_two_moduli_solver_unit
  import crt_pkg::*;
#(
  parameter int WIDTH = DefWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // residue_a[15:0], residue_b[31:16], modulus_a[47:32], modulus_b[63:48]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // solution[31:0], combined_modulus[63:32], common_divisor[79:64], status[80]
  output logic [87:0] m_tdata
);

  localparam int PW = 2 * WIDTH;
  localparam int CWD = WIDTH + 2;  // signed coefficient width
  localparam int TW = CWD + WIDTH + 1;  // coefficient*modulus
  localparam int DW = 3 * WIDTH + 3;  // coefficient*modulus*residue sums
  localparam int RC = $clog2(DW + 1);

  state_t state, state_next;

  logic [WIDTH-1:0] ra, rb, ma, mb, big, lesser;
  logic             a_big;
  logic signed [CWD-1:0] ubp, usp, ub, us;
  logic [PW-1:0]    prod;
  logic signed [TW-1:0] term;
  logic signed [DW-1:0] acc;
  logic [DW-1:0]    mag, rrem;
  logic             neg;
  logic [RC-1:0]    rcnt;
  logic [PW-1:0]    sol;
  logic [WIDTH-1:0] gcd;
  logic             stat;

  logic             div_start, div_done;
  logic [WIDTH-1:0] q, rem;
  logic [WIDTH-1:0] div_a, div_b;

  assign div_a = (state == ST_UPDATE) ? lesser : big;
  assign div_b = (state == ST_UPDATE) ? rem : lesser;

  crt_divider #(.N(WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(q), .remainder(rem)
  );

  logic [15:0] in_ra, in_rb, in_ma, in_mb;
  assign in_ra = s_tdata[15:0];
  assign in_rb = s_tdata[31:16];
  assign in_ma = s_tdata[47:32];
  assign in_mb = s_tdata[63:48];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {7'd0, stat, 16'(gcd), 32'(prod), 32'(sol)};

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_GCD_INIT;
      ST_GCD_INIT: begin
        if (big == '0 || lesser == '0) state_next = ST_OUT;
        else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV:      if (div_done) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (rem == '0) state_next = ST_MUL_A0;
        else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_MUL_A0:   state_next = ST_MUL_A1;
      ST_MUL_A1:   state_next = ST_MUL_B0;
      ST_MUL_B0:   state_next = ST_MUL_B1;
      ST_MUL_B1:   state_next = ST_RED_INIT;
      ST_RED_INIT: state_next = ST_RED;
      ST_RED:      if (rcnt == '0) state_next = ST_FIX;
      ST_FIX:      state_next = ST_OUT;
      ST_OUT:      if (m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic [DW-1:0] rtrial;
  logic [DW:0]   rdiff;
  assign rtrial = {rrem[DW-2:0], mag[DW-1]};
  assign rdiff  = {1'b0, rtrial} - {{(DW + 1 - PW){1'b0}}, prod};

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_tvalid) begin
        ra    <= WIDTH'(in_ra);
        rb    <= WIDTH'(in_rb);
        ma    <= WIDTH'(in_ma);
        mb    <= WIDTH'(in_mb);
        a_big <= WIDTH'(in_ma) > WIDTH'(in_mb);
        big   <= (WIDTH'(in_ma) > WIDTH'(in_mb)) ? WIDTH'(in_ma) : WIDTH'(in_mb);
        lesser <= (WIDTH'(in_ma) > WIDTH'(in_mb)) ? WIDTH'(in_mb) : WIDTH'(in_ma);
        ubp <= CWD'(1); usp <= '0; ub <= '0; us <= CWD'(1);
      end
      ST_GCD_INIT: begin
        prod <= PW'(ma) * PW'(mb);
        gcd  <= big;
        stat <= 1'b1;
        sol  <= '0;
        if (lesser != '0 && big != '0) begin
          ubp <= CWD'(1); usp <= '0; ub <= '0; us <= CWD'(1);
        end
      end
      ST_UPDATE: begin
        if (rem == '0) begin
          gcd  <= lesser;
          stat <= (lesser != WIDTH'(1));
          acc  <= '0;
        end else begin
          ub  <= ubp - $signed({1'b0, q}) * ub;
          us  <= usp - $signed({1'b0, q}) * us;
          ubp <= ub;
          usp <= us;
          big <= lesser;
          lesser <= rem;
        end
      end
      ST_MUL_A0: term <= TW'(a_big ? ub : us) * $signed({1'b0, ma});
      ST_MUL_A1: acc  <= acc + DW'(term) * $signed({1'b0, rb});
      ST_MUL_B0: term <= TW'(a_big ? us : ub) * $signed({1'b0, mb});
      ST_MUL_B1: acc  <= acc + DW'(term) * $signed({1'b0, ra});
      ST_RED_INIT: begin
        neg  <= acc[DW-1];
        mag  <= acc[DW-1] ? DW'(-acc) : DW'(acc);
        rrem <= '0;
        rcnt <= RC'(DW);
      end
      ST_RED: if (rcnt != '0) begin
        mag  <= {mag[DW-2:0], 1'b0};
        rrem <= rdiff[DW] ? rtrial : rdiff[DW-1:0];
        rcnt <= rcnt - 1'b1;
      end
      ST_FIX: begin
        if (!stat)
          sol <= (neg && rrem != '0) ? PW'(prod - PW'(rrem)) : PW'(rrem);
      end
      default: ;
    endcase
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-moduli CRT solver: a directed table of
// edge cases, then random congruence pairs under bursty input and a stalling
// output side, each result checked against an extended-Euclid predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumRandom = 750;
  localparam int MaxCycles = 4000000;

  typedef struct packed {
    logic [15:0] mod_b;
    logic [15:0] mod_a;
    logic [15:0] res_b;
    logic [15:0] res_a;
  } crt_in_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        not_coprime;
    logic [15:0] gcd;
    logic [31:0] product;
    logic [31:0] solution;
  } crt_out_t;

  typedef struct {
    crt_in_t  word;
    logic     known;
    crt_out_t result;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  crt_out_t   expected_q[$];
  crt_out_t   typed_q[$];
  logic       typed_flag_q[$];
  int         errors = 0;
  int         cycles = 0;
  bit         sent_all = 1'b0;
  bit         hold_off = 1'b0;
  dir_row_t   dir_rows[$];

  always #1 clk = ~clk;

  crt_two_moduli_solver_unit #(.WIDTH(16)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic crt_out_t solve_crt(crt_in_t w);
    crt_out_t o;
    longint ra, rb, ma, mb, hi, lo, ub, us, ubp, usp, q, rm, nu, nv, ca, cb, d, r, prod;
    bit a_big;
    ra = longint'(w.res_a); rb = longint'(w.res_b);
    ma = longint'(w.mod_a); mb = longint'(w.mod_b);
    a_big = ma > mb;
    hi = a_big ? ma : mb;
    lo = a_big ? mb : ma;
    prod = ma * mb;
    o = '0;
    o.product = prod[31:0];
    if (hi == 0 || lo == 0) begin
      o.gcd = hi[15:0];
      o.not_coprime = 1'b1;
      return o;
    end
    ubp = 1; usp = 0; ub = 0; us = 1;
    while (hi % lo != 0) begin
      q = hi / lo;
      rm = hi % lo;
      nu = ubp - q * ub;
      nv = usp - q * us;
      ubp = ub; usp = us; ub = nu; us = nv;
      hi = lo; lo = rm;
    end
    if (a_big) begin
      ca = ub; cb = us;
    end else begin
      ca = us; cb = ub;
    end
    d = ca * ma * rb + cb * mb * ra;
    r = d % prod;
    if (r < 0) r += prod;
    o.gcd = lo[15:0];
    o.not_coprime = (lo != 1);
    o.solution = (lo == 1) ? r[31:0] : 32'd0;
    return o;
  endfunction

  function automatic crt_in_t pick_word();
    crt_in_t w;
    int k;
    k = $urandom_range(0, 9);
    w.res_a = 16'($urandom); w.res_b = 16'($urandom);
    w.mod_a = 16'($urandom); w.mod_b = 16'($urandom);
    if (k < 3) begin
      w.mod_a = 16'($urandom_range(1, 255));
      w.mod_b = 16'($urandom_range(1, 255));
      w.res_a = 16'($urandom_range(0, 300));
      w.res_b = 16'($urandom_range(0, 300));
    end else if (k == 3) begin
      w.mod_b = w.mod_a;
    end else if (k == 4) begin
      w.mod_a = 16'(65535 - $urandom_range(0, 3));
      w.mod_b = 16'(65535 - $urandom_range(0, 7));
    end
    if (w.mod_a == 0) w.mod_a = 16'd1;
    if (w.mod_b == 0) w.mod_b = 16'd1;
    return w;
  endfunction

  task automatic send_word(crt_in_t w);
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic add_row(int ra, int rb, int ma, int mb, int kn, int sol,
                         int prod, int g, int st);
    dir_row_t row;
    row.word = '{mod_b: 16'(mb), mod_a: 16'(ma), res_b: 16'(rb), res_a: 16'(ra)};
    row.known = 1'(kn);
    row.result = '{pad: '0, not_coprime: 1'(st), gcd: 16'(g), product: 32'(prod),
                   solution: 32'(sol)};
    dir_rows = {dir_rows, row};
  endtask

  initial begin
    int gap;
    int burst;
    add_row(0, 0, 1, 1, 1, 0, 1, 1, 0);
    add_row(65535, 65535, 1, 1, 1, 0, 1, 1, 0);
    add_row(0, 0, 65535, 65535, 1, 0, 32'hFFFE0001, 65535, 1);
    add_row(5, 7, 4, 6, 1, 0, 24, 2, 1);
    add_row(0, 0, 3, 5, 1, 0, 15, 1, 0);
    add_row(3, 5, 3, 5, 1, 0, 15, 1, 0);
    add_row(2, 3, 3, 5, 0, 0, 0, 0, 0);
    add_row(65535, 65535, 65535, 65534, 0, 0, 0, 0, 0);
    add_row(43690, 21845, 65534, 65535, 0, 0, 0, 0, 0);
    add_row(1, 0, 32768, 32767, 0, 0, 0, 0, 0);
    add_row(100, 200, 7, 11, 0, 0, 0, 0, 0);
    add_row(4, 9, 1, 65535, 0, 0, 0, 0, 0);
    add_row(4660, 17185, 46368, 28657, 0, 0, 0, 0, 0);
    add_row(1, 2, 12, 18, 1, 0, 216, 6, 1);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      expected_q = {expected_q, solve_crt(dir_rows[i].word)};
      typed_q = {typed_q, dir_rows[i].result};
      typed_flag_q = {typed_flag_q, dir_rows[i].known};
      send_word(dir_rows[i].word);
    end
    burst = 0;
    for (int n = 0; n < NumRandom; n++) begin
      crt_in_t w;
      if (n == 40) hold_off = 1'b1;
      if (burst == 0) begin
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      w = pick_word();
      expected_q = {expected_q, solve_crt(w)};
      typed_q = {typed_q, crt_out_t'('0)};
      typed_flag_q = {typed_flag_q, 1'b0};
      send_word(w);
      burst--;
    end
    s_tvalid <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      mode = (cycles / 5000) % 3;
      if (mode == 0) m_tready <= 1'b1;
      else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
      else m_tready <= ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin
    crt_out_t got, want, typed;
    logic kn;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      got.pad = '0;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        typed = typed_q.pop_front();
        kn = typed_flag_q.pop_front();
        if (kn && typed != want) begin
          $display("%0t: table row expected %h actual %h", $realtime, typed, want);
          errors++;
        end
        if (got.solution != want.solution) begin
          $display("%0t: solution expected %0d actual %0d", $realtime, want.solution,
                   got.solution);
          errors++;
        end
        if (got.product != want.product) begin
          $display("%0t: combined_modulus expected %0d actual %0d", $realtime,
                   want.product, got.product);
          errors++;
        end
        if (got.gcd != want.gcd) begin
          $display("%0t: common_divisor expected %0d actual %0d", $realtime, want.gcd,
                   got.gcd);
          errors++;
        end
        if (got.not_coprime != want.not_coprime) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.not_coprime,
                   got.not_coprime);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("** crt_two_moduli_solver_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (sent_all);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** crt_two_moduli_solver_unit: PASSED **");
    end else begin
      $display("** crt_two_moduli_solver_unit: FAILED **");
    end
    $finish;
  end
endmodule
